// ===== rtl/tbpc_pkg.sv =====
// shared widths and event codes for the two-button press classifier
// no dependencies; used by tbpc_debounce and two_button_press_classifier
package tbpc_pkg;

    localparam int TIME_W   = 32;
    localparam int DEB_W    = 16;
    localparam int EVENT_W  = 3;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    localparam logic [EVENT_W-1:0] EV_NONE         = 3'd0;
    localparam logic [EVENT_W-1:0] EV_BOTH_LONG    = 3'd1;
    localparam logic [EVENT_W-1:0] EV_ID_LONG_END  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_ID_SHORT     = 3'd3;
    localparam logic [EVENT_W-1:0] EV_EXEC_PRESS   = 3'd4;
    localparam logic [EVENT_W-1:0] EV_EXEC_RELEASE = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS = 8'd1;

    typedef logic [TIME_W-1:0] time_ms_t;

endpackage

// ===== rtl/tbpc_debounce.sv =====
// lockout debouncer for one button: holds the debounced level and last change time
// depends on tbpc_pkg
module tbpc_debounce (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  tbpc_pkg::time_ms_t           now,
    input  logic                         raw,
    input  logic [tbpc_pkg::DEB_W-1:0]   debounce_ms,
    output logic                         level,
    output logic                         level_next
);

    logic               level_reg;
    tbpc_pkg::time_ms_t change_time_reg;
    tbpc_pkg::time_ms_t change_time_next;
    tbpc_pkg::time_ms_t elapsed;
    logic               take_change;

    // elapsed time wraps modulo 2^32
    assign elapsed     = now - change_time_reg;
    assign take_change = (raw != level_reg) &&
                         (elapsed > {{(tbpc_pkg::TIME_W-tbpc_pkg::DEB_W){1'b0}}, debounce_ms});

    assign level_next       = take_change ? raw : level_reg;
    assign change_time_next = take_change ? now : change_time_reg;
    assign level            = level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg       <= 1'b0;
            change_time_reg <= '0;
        end else if (en) begin
            level_reg       <= level_next;
            change_time_reg <= change_time_next;
        end
    end

endmodule

// ===== rtl/two_button_press_classifier.sv =====
// two-button press classifier: input register, debounce, press classification, output register
// depends on tbpc_pkg and tbpc_debounce
//
// Usage: samples arrive on the s_ stream, one per transfer, each with a
// millisecond time, the raw id and exec levels and a take bit. Every sample
// gives exactly one result on the m_ stream: the pending event, the two
// debounced levels and the last exec hold time. A sample with take set
// clears the pending event after its result is formed.
// The cfg_ channel writes debounce_ms (index 0) and long_press_ms
// (index 1); other indexes are ignored. It is always ready and is meant to
// be written while no sample is in flight.
// A sample is held in the input register, then its result is loaded into
// the output register, which drives m_tvalid.
// Throughput is one sample per cycle while the m_ side takes results,
// set by the single pass of compare and subtract logic that updates
// the press state.
// A stalled m_ side holds the result; the input register still takes one
// more sample, then s_tready drops until the result is taken.
// Reset (aresetn low, synchronous) clears both register valid bits, all press state
// and the pending event, and restores the register defaults 50 and 3000.
module two_button_press_classifier (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] time_ms, [32] id_pressed, [33] exec_pressed, [34] take_event, rest zero
    input  logic [tbpc_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [2:0] event_res, [3] id_state, [4] exec_state, [36:5] exec_duration, rest zero
    output logic [tbpc_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tbpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tbpc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // configuration
    logic [tbpc_pkg::DEB_W-1:0] debounce_ms_reg;
    tbpc_pkg::time_ms_t         long_press_ms_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ms_reg   <= 16'd50;
            long_press_ms_reg <= 32'd3000;
        end else if (cfg_valid) begin
            case (cfg_index)
                tbpc_pkg::REG_DEBOUNCE_MS: begin
                    debounce_ms_reg <= cfg_data[tbpc_pkg::DEB_W-1:0];
                end
                tbpc_pkg::REG_LONG_PRESS_MS: begin
                    long_press_ms_reg <= cfg_data[tbpc_pkg::TIME_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input register
    logic               in_valid_reg;
    tbpc_pkg::time_ms_t in_time_reg;
    logic               in_id_reg;
    logic               in_exec_reg;
    logic               in_take_reg;
    logic               out_valid_reg;
    logic               advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_time_reg <= s_tdata[tbpc_pkg::TIME_W-1:0];
            in_id_reg   <= s_tdata[32];
            in_exec_reg <= s_tdata[33];
            in_take_reg <= s_tdata[34];
        end
    end

    // debouncers
    logic id_level;
    logic id_next;
    logic exec_level;
    logic exec_next;

    tbpc_debounce u_id_deb (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (advance),
        .now         (in_time_reg),
        .raw         (in_id_reg),
        .debounce_ms (debounce_ms_reg),
        .level       (id_level),
        .level_next  (id_next)
    );

    tbpc_debounce u_exec_deb (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (advance),
        .now         (in_time_reg),
        .raw         (in_exec_reg),
        .debounce_ms (debounce_ms_reg),
        .level       (exec_level),
        .level_next  (exec_next)
    );

    // press state
    tbpc_pkg::time_ms_t             id_press_time_reg,   id_press_time_next;
    logic                           id_press_valid_reg,  id_press_valid_next;
    tbpc_pkg::time_ms_t             exec_press_time_reg, exec_press_time_next;
    logic                           exec_press_valid_reg, exec_press_valid_next;
    tbpc_pkg::time_ms_t             both_press_time_reg, both_press_time_next;
    logic                           both_press_valid_reg, both_press_valid_next;
    logic                           lock_reg,            lock_next;
    logic [tbpc_pkg::EVENT_W-1:0]   pending_reg,         pending_next;
    tbpc_pkg::time_ms_t             held_duration_reg,   held_duration_next;
    logic [tbpc_pkg::EVENT_W-1:0]   event_now;

    always_comb begin
        logic both;
        logic done;
        id_press_time_next    = id_press_time_reg;
        id_press_valid_next   = id_press_valid_reg;
        exec_press_time_next  = exec_press_time_reg;
        exec_press_valid_next = exec_press_valid_reg;
        both_press_time_next  = both_press_time_reg;
        both_press_valid_next = both_press_valid_reg;
        lock_next             = lock_reg;
        held_duration_next    = held_duration_reg;
        event_now             = pending_reg;
        both                  = id_next && exec_next;
        done                  = 1'b0;

        if (lock_reg) begin
            if (!id_next && !exec_next) begin
                lock_next = 1'b0;
            end
        end else begin
            if (both) begin
                if (!both_press_valid_next) begin
                    both_press_time_next  = in_time_reg;
                    both_press_valid_next = 1'b1;
                end
                id_press_valid_next   = 1'b0;
                exec_press_valid_next = 1'b0;
            end

            if (both_press_valid_next) begin
                if (!both) begin
                    both_press_valid_next = 1'b0;
                end else if ((in_time_reg - both_press_time_next) >= long_press_ms_reg) begin
                    event_now             = tbpc_pkg::EV_BOTH_LONG;
                    both_press_valid_next = 1'b0;
                    lock_next             = 1'b1;
                    done                  = 1'b1;
                end
            end

            if (!done) begin
                if (id_next && !exec_next && !id_press_valid_next) begin
                    id_press_time_next  = in_time_reg;
                    id_press_valid_next = 1'b1;
                end else if (!id_next && id_press_valid_next) begin
                    if ((in_time_reg - id_press_time_next) >= long_press_ms_reg) begin
                        event_now = tbpc_pkg::EV_ID_LONG_END;
                    end else begin
                        event_now = tbpc_pkg::EV_ID_SHORT;
                    end
                    id_press_valid_next = 1'b0;
                end

                if (exec_next && !id_next && !exec_press_valid_next) begin
                    exec_press_time_next  = in_time_reg;
                    exec_press_valid_next = 1'b1;
                    event_now             = tbpc_pkg::EV_EXEC_PRESS;
                end else if (!exec_next && exec_press_valid_next) begin
                    held_duration_next    = in_time_reg - exec_press_time_next;
                    event_now             = tbpc_pkg::EV_EXEC_RELEASE;
                    exec_press_valid_next = 1'b0;
                end
            end
        end

        pending_next = in_take_reg ? tbpc_pkg::EV_NONE : event_now;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_press_time_reg    <= '0;
            id_press_valid_reg   <= 1'b0;
            exec_press_time_reg  <= '0;
            exec_press_valid_reg <= 1'b0;
            both_press_time_reg  <= '0;
            both_press_valid_reg <= 1'b0;
            lock_reg             <= 1'b0;
            pending_reg          <= tbpc_pkg::EV_NONE;
            held_duration_reg    <= '0;
        end else if (advance) begin
            id_press_time_reg    <= id_press_time_next;
            id_press_valid_reg   <= id_press_valid_next;
            exec_press_time_reg  <= exec_press_time_next;
            exec_press_valid_reg <= exec_press_valid_next;
            both_press_time_reg  <= both_press_time_next;
            both_press_valid_reg <= both_press_valid_next;
            lock_reg             <= lock_next;
            pending_reg          <= pending_next;
            held_duration_reg    <= held_duration_next;
        end
    end

    // output register
    logic [tbpc_pkg::EVENT_W-1:0] out_event_reg;
    logic                         out_id_reg;
    logic                         out_exec_reg;
    tbpc_pkg::time_ms_t           out_duration_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_event_reg    <= event_now;
            out_id_reg       <= id_next;
            out_exec_reg     <= exec_next;
            out_duration_reg <= held_duration_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_duration_reg, out_exec_reg, out_id_reg, out_event_reg};

    // entering the lock always reports a both-long event
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !lock_reg && lock_next) |=>
            (m_tvalid && out_event_reg == tbpc_pkg::EV_BOTH_LONG))
        else $error("lock entered without both-long event");

    // single-button presses are never tracked together
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(id_press_valid_reg && exec_press_valid_reg))
        else $error("id and exec press tracked at once");

    // a tracked both-press implies both debounced levels are held
    assert property (@(posedge aclk) disable iff (!aresetn)
        both_press_valid_reg |-> (id_level && exec_level))
        else $error("both-press tracked without both buttons down");

    // the output event is always a defined code while m_tvalid is high
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_event_reg <= tbpc_pkg::EV_EXEC_RELEASE))
        else $error("undefined event code on output");

endmodule
